>>> rtl/pid_controller_with_plant_defines.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_WITH_PLANT_DEFINES_SVH
`define PID_CONTROLLER_WITH_PLANT_DEFINES_SVH

// Check outside reset.
`define PCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check at every edge, reset included.
`define PCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/pcp_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Payload and configuration types, codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package pcp_pkg;

  // Tick kinds; the unused code acts as a hold.
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_HOLD    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_KP        = 3'd0;
  localparam logic [2:0] CFG_KI        = 3'd1;
  localparam logic [2:0] CFG_KD        = 3'd2;
  localparam logic [2:0] CFG_TOLERANCE = 3'd3;
  localparam logic [2:0] CFG_INIT      = 3'd4;

  localparam logic signed [23:0] KP_RESET   = 24'sd65536;
  localparam logic [30:0]        TOL_RESET  = 31'd328;
  localparam logic signed [31:0] INIT_RESET = 32'sd65536;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] reference;
  } pcp_item_t;

  typedef struct packed {
    logic signed [31:0] plant_out;
    logic signed [31:0] error_out;
    logic signed [31:0] command_out;
    logic               settled;
  } pcp_result_t;

  typedef struct packed {
    logic signed [23:0] kp;
    logic signed [23:0] ki_times_period;
    logic signed [23:0] kd_over_period;
    logic [30:0]        tolerance;
    logic signed [31:0] initial_state;
  } pcp_cfg_t;

  typedef struct packed {
    logic signed [31:0] plant_value;
    logic signed [31:0] next_plant;
    logic               update_pending;
    logic signed [47:0] error_sum;
    logic signed [31:0] error_prev;
  } pcp_state_t;

endpackage

`default_nettype wire

>>> rtl/pid_controller_with_plant.sv
// ----------------------------------------------------------------------------
// PID controller with integrating plant
// Discrete PID loop around a simulated plant, one tick per input transfer.
//
//   channel  signals                              direction
//   in       in_valid, in_ready, in_item          tick kind and reference in
//   out      out_valid, out_ready, out_result     plant, error, command out
//   cfg      cfg_valid, cfg_ready, cfg_index/data register writes in
//
// One item per cycle sustained while out_ready stays high; a result passes
// the input register and then the tick datapath into the result register
// before it is presented. The datapath and the controller state
// update in that one step.
// Reset is synchronous and needs no clearing pass; cfg_ready stays high.
// A stalled result holds the input register, which in turn drops in_ready.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pid_controller_with_plant_defines.svh"

module pid_controller_with_plant (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcp_pkg::pcp_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pcp_pkg::pcp_result_t out_result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import pcp_pkg::*;

  pcp_cfg_t    cfg;
  pcp_item_t   item;
  logic        item_full;
  logic        move;
  pcp_state_t  state;
  pcp_state_t  state_next;
  pcp_result_t result;

  assign cfg_ready = 1'b1;

  pcp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pcp_step u_step (
    .item       (item),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  // Advance the held item when the result register is free.
  assign move     = item_full && (!out_valid || out_ready);
  assign in_ready = !item_full || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else begin
      item_full <= (in_valid && in_ready) || (item_full && !move);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.plant_value    <= INIT_RESET;
      state.next_plant     <= '0;
      state.update_pending <= 1'b0;
      state.error_sum      <= '0;
      state.error_prev     <= '0;
    end else if (move) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= move || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_result <= result;
    end
  end

  `PCP_ASSERT_ALWAYS(a_idle_after_reset, $past(rst) |-> !out_valid && in_ready, "not idle after reset")
  `PCP_ASSERT(a_settled_no_cmd, out_valid && out_result.settled |-> out_result.command_out == 32'sd0, "settled result carries a command")
  `PCP_ASSERT(a_stall_blocks_in, item_full && out_valid && !out_ready |-> !in_ready, "input taken while output stalled with item held")
  `PCP_ASSERT(a_state_only_on_move, !$past(rst) && !$past(move) |-> $stable(state), "controller state changed without a tick")
  `PCP_ASSERT(a_restart_clears, move && item.kind == KIND_RESTART |=> !state.update_pending && state.error_sum == 48'sd0, "restart left pending state")

endmodule

`default_nettype wire

>>> rtl/pcp_cfg.sv
// ----------------------------------------------------------------------------
// PID controller configuration registers
// Decodes register writes into the gain, tolerance and initial-value set.
// ----------------------------------------------------------------------------
`default_nettype none

module pcp_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [2:0]       wr_index,
  input  logic [31:0]      wr_data,
  output pcp_pkg::pcp_cfg_t cfg
);
  import pcp_pkg::*;

  pcp_cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      unique case (wr_index)
        CFG_KP:        cfg_next.kp              = wr_data[23:0];
        CFG_KI:        cfg_next.ki_times_period = wr_data[23:0];
        CFG_KD:        cfg_next.kd_over_period  = wr_data[23:0];
        CFG_TOLERANCE: cfg_next.tolerance       = wr_data[30:0];
        CFG_INIT:      cfg_next.initial_state   = wr_data;
        default:       cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp              <= KP_RESET;
      cfg.ki_times_period <= '0;
      cfg.kd_over_period  <= '0;
      cfg.tolerance       <= TOL_RESET;
      cfg.initial_state   <= INIT_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcp_step.sv
// ----------------------------------------------------------------------------
// PID controller tick datapath
// One item: settle test, error sum, PID command and next plant value, or a restart or hold.
// ----------------------------------------------------------------------------
`default_nettype none

module pcp_step (
  input  pcp_pkg::pcp_item_t   item,
  input  pcp_pkg::pcp_cfg_t    cfg,
  input  pcp_pkg::pcp_state_t  state,
  output pcp_pkg::pcp_state_t  state_next,
  output pcp_pkg::pcp_result_t result
);
  import pcp_pkg::*;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) sat33 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else                sat33 = v[31:0];
  endfunction

  logic signed [31:0] ref_val;
  logic signed [31:0] base_plant;
  logic signed [32:0] diff_base;
  logic [32:0]        mag;
  logic               in_band;

  logic signed [31:0] step_plant;
  logic signed [32:0] diff_step;
  logic signed [31:0] e;
  logic signed [48:0] sum_wide;
  logic signed [47:0] sum_new;
  logic signed [32:0] de;
  logic [15:0]        sum_lo;
  logic signed [31:0] sum_hi;
  logic signed [55:0] p_kp;
  logic signed [56:0] p_kd;
  logic signed [40:0] p_ki_lo;
  logic signed [55:0] p_ki_hi;
  logic signed [57:0] acc;
  logic signed [56:0] cmd_wide;
  logic signed [31:0] cmd;
  logic signed [32:0] plant_sum;

  assign ref_val    = $signed(item.reference);
  assign base_plant = (item.kind == KIND_RESTART) ? $signed(cfg.initial_state)
                                                  : $signed(state.plant_value);
  assign diff_base  = {ref_val[31], ref_val} - {base_plant[31], base_plant};
  assign mag        = diff_base[32] ? 33'(-diff_base) : 33'(diff_base);
  assign in_band    = (mag <= {2'b00, cfg.tolerance});

  // Step path: apply the pending update first.
  assign step_plant = state.update_pending ? $signed(state.next_plant)
                                           : $signed(state.plant_value);
  assign diff_step  = {ref_val[31], ref_val} - {step_plant[31], step_plant};
  assign e          = sat33(diff_step);

  assign sum_wide = {state.error_sum[47], state.error_sum} + 49'($signed(e));
  always_comb begin
    if (sum_wide[48] != sum_wide[47])
      sum_new = sum_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else
      sum_new = sum_wide[47:0];
  end

  assign de     = {e[31], e} - {state.error_prev[31], state.error_prev};
  assign sum_lo = sum_new[15:0];
  assign sum_hi = sum_new[47:16];

  assign p_kp    = $signed(cfg.kp) * e;
  assign p_kd    = $signed(cfg.kd_over_period) * de;
  assign p_ki_lo = $signed(cfg.ki_times_period) * $signed({1'b0, sum_lo});
  assign p_ki_hi = $signed(cfg.ki_times_period) * sum_hi;

  assign acc = 58'(p_kp) + 58'(p_kd) + 58'(p_ki_lo);
  // Arithmetic shift right by 16 rounds toward minus infinity.
  assign cmd_wide = 57'($signed(acc[57:16])) + 57'(p_ki_hi);

  always_comb begin
    if (cmd_wide[56:31] != {26{cmd_wide[31]}})
      cmd = cmd_wide[56] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else
      cmd = cmd_wide[31:0];
  end

  assign plant_sum = {step_plant[31], step_plant} + {cmd[31], cmd};

  always_comb begin
    state_next         = state;
    result.plant_out   = base_plant;
    result.error_out   = sat33(diff_base);
    result.command_out = '0;
    result.settled     = 1'b0;
    unique case (item.kind)
      KIND_TICK: begin
        if (in_band) begin
          state_next.update_pending = 1'b0;
          result.settled            = 1'b1;
        end else begin
          state_next.plant_value    = step_plant;
          state_next.next_plant     = sat33(plant_sum);
          state_next.update_pending = 1'b1;
          state_next.error_sum      = sum_new;
          state_next.error_prev     = e;
          result.plant_out          = step_plant;
          result.error_out          = e;
          result.command_out        = cmd;
        end
      end
      KIND_RESTART: begin
        state_next.plant_value    = cfg.initial_state;
        state_next.next_plant     = '0;
        state_next.update_pending = 1'b0;
        state_next.error_sum      = '0;
        state_next.error_prev     = '0;
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> tb/sv/pcp_loop_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID loop checker
// Watches the tick, result and register channels, keeps its own copy of the
// gains and the loop state, forms the expected result of each tick transfer
// and compares every result transfer against the oldest one still awaited.
// ----------------------------------------------------------------------------
module pcp_loop_checker
  import pcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  pcp_item_t   in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  pcp_result_t out_result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          failures,
  output int          outstanding
);

  localparam logic signed [63:0] SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_LO = -SUM_HI - 64'sd1;
  localparam logic signed [63:0] I32_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] I32_LO = -I32_HI - 64'sd1;

  pcp_cfg_t           gains;
  logic signed [31:0] plant_now;
  logic signed [31:0] plant_next;
  logic               step_pending;
  logic signed [47:0] err_sum;
  logic signed [31:0] err_prev;
  pcp_result_t        awaited_ticks[$];
  int                 result_no;

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > I32_HI) return I32_HI[31:0];
    if (v < I32_LO) return I32_LO[31:0];
    return v[31:0];
  endfunction

  // Advance the loop by one tick and return what the block must report.
  function automatic pcp_result_t advance_loop(input pcp_item_t it);
    logic signed [63:0] ref64, plant64, diff, mag, tol64;
    logic signed [63:0] e, de, sum, lo, hi, acc, cmd;
    logic signed [63:0] kp64, ki64, kd64;
    pcp_result_t        r;
    r = '0;
    ref64 = $signed(it.reference);
    cmd = 64'sd0;
    if (it.kind == KIND_RESTART) begin
      plant_now = gains.initial_state;
      plant_next = '0;
      step_pending = 1'b0;
      err_sum = '0;
      err_prev = '0;
    end
    plant64 = $signed(plant_now);
    diff = ref64 - plant64;
    if (it.kind == KIND_TICK) begin
      mag = (diff < 0) ? -diff : diff;
      tol64 = {33'b0, gains.tolerance};
      if (mag <= tol64) begin
        // within the band: drop the pending update, keep sum and history
        step_pending = 1'b0;
        r.settled = 1'b1;
      end else begin
        kp64 = $signed(gains.kp);
        ki64 = $signed(gains.ki_times_period);
        kd64 = $signed(gains.kd_over_period);
        if (step_pending) plant_now = plant_next;
        plant64 = $signed(plant_now);
        diff = ref64 - plant64;
        e = clip32(diff);
        sum = $signed(err_sum) + e;
        if (sum > SUM_HI) sum = SUM_HI;
        else if (sum < SUM_LO) sum = SUM_LO;
        err_sum = sum[47:0];
        de = e - $signed(err_prev);
        // split the sum so the integral term keeps full precision
        lo = {48'b0, sum[15:0]};
        hi = sum >>> 16;
        acc = kp64 * e + kd64 * de + ki64 * lo;
        cmd = clip32((acc >>> 16) + ki64 * hi);
        plant_next = clip32(plant64 + cmd);
        step_pending = 1'b1;
        err_prev = e[31:0];
      end
    end
    r.plant_out = plant_now;
    r.error_out = clip32(diff);
    r.command_out = cmd[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    pcp_result_t want;
    if (rst) begin
      gains.kp <= KP_RESET;
      gains.ki_times_period <= '0;
      gains.kd_over_period <= '0;
      gains.tolerance <= TOL_RESET;
      gains.initial_state <= INIT_RESET;
      plant_now = INIT_RESET;
      plant_next = '0;
      step_pending = 1'b0;
      err_sum = '0;
      err_prev = '0;
      awaited_ticks.delete();
      result_no = 0;
      failures = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KP:        gains.kp <= cfg_data[23:0];
          CFG_KI:        gains.ki_times_period <= cfg_data[23:0];
          CFG_KD:        gains.kd_over_period <= cfg_data[23:0];
          CFG_TOLERANCE: gains.tolerance <= cfg_data[30:0];
          CFG_INIT:      gains.initial_state <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        result_no++;
        if (awaited_ticks.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("result %0d: transfer with no tick awaiting it", result_no);
        end else begin
          want = awaited_ticks.pop_front();
          if (out_result.plant_out !== want.plant_out ||
              out_result.error_out !== want.error_out ||
              out_result.command_out !== want.command_out ||
              out_result.settled !== want.settled) begin
            failures++;
            if (failures <= 10) begin
              $display("result %0d: expected plant %0d error %0d command %0d settled %0d",
                       result_no, want.plant_out, want.error_out,
                       want.command_out, want.settled);
              $display("result %0d: got      plant %0d error %0d command %0d settled %0d",
                       result_no, out_result.plant_out, out_result.error_out,
                       out_result.command_out, out_result.settled);
            end
          end
        end
      end
      if (in_valid && in_ready)
        awaited_ticks.push_back(advance_loop(in_item));
    end
    outstanding = awaited_ticks.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller testbench
// Drives ticks, holds and restarts into the controller under several gain
// settings and handshake idling patterns; the loop checker predicts each
// result and this top reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import pcp_pkg::*;

  localparam logic [1:0]         KIND_SPARE  = 2'd3;
  localparam logic signed [31:0] REF_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] REF_MIN     = 32'sh8000_0000;
  localparam int                 IDLE_LIMIT  = 2000;
  localparam int                 DRAIN_GAP   = 6;
  localparam int                 PHASES      = 8;
  localparam int                 PHASE_ITEMS = 215;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  pcp_item_t          in_item;
  logic               out_valid;
  logic               out_ready;
  pcp_result_t        out_result;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 failures;
  int                 outstanding;
  int                 idle_pct;
  int                 stall_pct;
  int                 idle_run;
  int                 phase_count;
  logic signed [31:0] init_val;
  logic signed [31:0] target;

  always #4 clk = ~clk;

  pid_controller_with_plant uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_result(out_result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcp_loop_checker loop_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .failures   (failures),
    .outstanding(outstanding)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Called and returns just after a falling edge.
  task automatic send_tick(input logic [1:0] kind, input logic signed [31:0] refv);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item.kind <= kind;
    in_item.reference <= refv;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    phase_count++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Drop valid, let every awaited result out, then give the pipe time to empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic load_gains(input bit wild);
    logic [31:0] kp_w, ki_w, kd_w, tol_w;
    if (wild) begin
      kp_w = $urandom;
      ki_w = $urandom;
      kd_w = $urandom;
      tol_w = $urandom;
      init_val = $urandom;
    end else begin
      // gains that let the loop converge, so settling is reached
      kp_w = $urandom_range(65536, 6554);
      ki_w = $urandom_range(3000, 0);
      kd_w = $urandom_range(2000, 0);
      tol_w = $urandom_range(5000, 0);
      init_val = $signed($urandom_range(33554432, 0)) - 16777216;
    end
    write_reg(CFG_KP, kp_w);
    write_reg(CFG_KI, ki_w);
    write_reg(CFG_KD, kd_w);
    write_reg(CFG_TOLERANCE, tol_w);
    write_reg(CFG_INIT, init_val);
    if ($urandom_range(3) == 0)
      write_reg(3'($urandom_range(7, 5)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_ref();
    if ($urandom_range(9) == 0) return $urandom;
    return init_val + ($signed($urandom_range(4194304, 0)) - 2097152);
  endfunction

  // Restart, then mostly steer toward one reference with some holds and noise.
  task automatic run_episode();
    int len;
    int roll;
    len = $urandom_range(40, 5);
    send_tick(KIND_RESTART, pick_ref());
    target = pick_ref();
    repeat (len) begin
      roll = $urandom_range(99);
      if (roll < 5) target = pick_ref();
      if (roll < 80) send_tick(KIND_TICK, target);
      else if (roll < 88) send_tick(KIND_HOLD, $urandom);
      else if (roll < 92) send_tick(KIND_SPARE, $urandom);
      else if (roll < 96) send_tick(2'($urandom_range(3)), $urandom);
      else send_tick(KIND_TICK, $urandom);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    idle_run = 0;
    phase_count = 0;
    init_val = INIT_RESET;
    target = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset gains: band edges, holds, saturated errors
    send_tick(KIND_TICK, INIT_RESET);
    send_tick(KIND_TICK, INIT_RESET + TOL_RESET);
    send_tick(KIND_TICK, INIT_RESET - TOL_RESET);
    send_tick(KIND_TICK, INIT_RESET + TOL_RESET + 1);
    send_tick(KIND_HOLD, '0);
    send_tick(KIND_SPARE, REF_MAX);
    send_tick(KIND_TICK, INIT_RESET + TOL_RESET + 1);
    send_tick(KIND_TICK, REF_MAX);
    send_tick(KIND_TICK, REF_MIN);
    send_tick(KIND_RESTART, '0);
    send_tick(KIND_TICK, REF_MIN);
    send_tick(KIND_TICK, REF_MAX);
    send_tick(KIND_RESTART, REF_MIN);

    // extreme gains, zero band
    wait_idle();
    write_reg(CFG_KP, 32'h007F_FFFF);
    write_reg(CFG_KI, 32'h0080_0000);
    write_reg(CFG_KD, 32'h007F_FFFF);
    write_reg(CFG_TOLERANCE, 32'h0000_0000);
    write_reg(CFG_INIT, REF_MIN);
    cfg_valid <= 1'b0;
    init_val = REF_MIN;
    send_tick(KIND_RESTART, REF_MAX);
    send_tick(KIND_TICK, REF_MIN);
    send_tick(KIND_TICK, REF_MAX);
    send_tick(KIND_TICK, REF_MIN);
    send_tick(KIND_TICK, REF_MAX);
    send_tick(KIND_HOLD, REF_MIN);
    send_tick(KIND_TICK, '0);

    // opposite extremes, widest band; upper data bits must be ignored
    wait_idle();
    write_reg(CFG_KP, 32'hFF80_0000);
    write_reg(CFG_KI, 32'h007F_FFFF);
    write_reg(CFG_KD, 32'hFF80_0000);
    write_reg(CFG_TOLERANCE, 32'hFFFF_FFFF);
    write_reg(CFG_INIT, REF_MAX);
    cfg_valid <= 1'b0;
    init_val = REF_MAX;
    send_tick(KIND_RESTART, REF_MIN);
    send_tick(KIND_TICK, REF_MIN);
    send_tick(KIND_TICK, REF_MIN);
    send_tick(KIND_TICK, '0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      load_gains($urandom_range(3) == 0);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) run_episode();
    end

    wait_idle();
    if (failures == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/pcp_pkg.sv
rtl/pcp_cfg.sv
rtl/pcp_step.sv
rtl/pid_controller_with_plant.sv
tb/sv/pcp_loop_checker.sv
tb/sv/tb.sv
